// ===== src/gblit_pkg.sv =====
package gblit_pkg;

  localparam int ROWS      = 8;
  localparam int COL_BYTES = 8;
  localparam int DEPTH     = ROWS * COL_BYTES;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ACT_BLIT  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef logic [ADDR_W-1:0] addr_t;

  // byte address of a row and column byte, both already known to be in range
  function automatic addr_t mk_addr(input logic [5:0] row, input logic [4:0] col);
    int lin;
    lin = int'(row) * COL_BYTES + int'(col);
    return lin[ADDR_W-1:0];
  endfunction

  // msb-aligned run of width ones, width already saturated to 8
  function automatic logic [7:0] full_mask(input logic [3:0] width);
    return ~(8'hFF >> width);
  endfunction

endpackage

// ===== src/gblit_in_if.sv =====
interface gblit_in_if;
  import gblit_pkg::*;

  logic              valid;
  logic              ready;
  action_t           action;
  logic [7:0]        glyph_bits;
  logic [3:0]        glyph_width;
  logic [5:0]        glyph_line;
  logic signed [7:0] row_offset;
  logic signed [10:0] col_offset;
  logic [5:0]        read_row;
  logic [4:0]        read_byte_index;

  modport source (
    output valid, action, glyph_bits, glyph_width, glyph_line, row_offset,
           col_offset, read_row, read_byte_index,
    input  ready
  );

  modport sink (
    input  valid, action, glyph_bits, glyph_width, glyph_line, row_offset,
           col_offset, read_row, read_byte_index,
    output ready
  );
endinterface

// ===== src/gblit_out_if.sv =====
interface gblit_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [3:0] width_echo;

  modport source (output valid, read_data, width_echo, input ready);
  modport sink (input valid, read_data, width_echo, output ready);
endinterface

// ===== src/glyph_row_blit_framebuffer_top.sv =====
// clear, fill, out-of-range reads and blits touching no byte go straight to done; a read
// or a one-byte blit passes issue and merge, a two-byte blit issue, merge, issue, merge
// a new item is taken only in idle, once the last result is registered: the single memory
// port does one read-modify-write per byte; clear and fill act at once via valid bits
// reset (synchronous, active low) empties the frame store to all zero and drops any result
module glyph_row_blit_framebuffer_top (
  input  logic              clk,
  input  logic              rst_n,
  gblit_in_if.sink          in_ch,
  gblit_out_if.source       out_ch
);
  import gblit_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_MERGE,
    S_DONE
  } state_t;

  state_t     state_r;
  action_t    act_r;
  addr_t      addr_r;
  addr_t      addr1_r;
  logic       sel_r;
  logic       pend1_r;
  logic [7:0] m0_r, g0_r, m1_r, g1_r;
  logic [7:0] rdata_r;
  logic [3:0] wecho_r;
  logic       out_valid_r;
  logic [7:0] out_rdata_r;
  logic [3:0] out_wecho_r;

  // frame store: valid bits plus a background byte stand in for the bulk clear and fill
  logic [7:0]       mem [DEPTH];
  logic [7:0]       mem_q;
  logic [DEPTH-1:0] valid_r;
  logic [7:0]       bg_r;

  // decode of the incoming item
  logic              in_xfer;
  logic [3:0]        width_sat;
  logic signed [8:0] row_s;
  logic              row_ok;
  logic [7:0]        bidx;
  logic [8:0]        bidx1;
  logic [2:0]        shift;
  logic              b0_ok, b1_ok;
  logic              rd_ok;
  logic [7:0]        full;
  logic              blit_go0, blit_go1;

  always_comb begin
    in_xfer   = in_ch.valid && in_ch.ready;
    width_sat = (in_ch.glyph_width > 4'd8) ? 4'd8 : in_ch.glyph_width;
    row_s     = $signed({3'b000, in_ch.glyph_line}) +
                $signed({in_ch.row_offset[7], in_ch.row_offset});
    row_ok    = !row_s[8] && ({1'b0, row_s[7:0]} < 9'(ROWS));
    bidx      = in_ch.col_offset[10:3];
    bidx1     = {bidx[7], bidx} + 9'd1;
    shift     = in_ch.col_offset[2:0];
    b0_ok     = !bidx[7] && (bidx < 8'(COL_BYTES));
    b1_ok     = !bidx1[8] && (bidx1 < 9'(COL_BYTES)) && (shift != 3'd0);
    rd_ok     = ({1'b0, in_ch.read_row} < 7'(ROWS)) &&
                ({1'b0, in_ch.read_byte_index} < 6'(COL_BYTES));
    full      = full_mask(width_sat);
    blit_go0  = (in_ch.action == ACT_BLIT) && row_ok && b0_ok;
    blit_go1  = (in_ch.action == ACT_BLIT) && row_ok && b1_ok;
  end

  // read-modify-write path
  logic [7:0] old_byte;
  logic [7:0] mrg_mask, mrg_bits, mrg_byte;
  logic       mem_we;
  addr_t      mem_ra;

  always_comb begin
    old_byte = valid_r[addr_r] ? mem_q : bg_r;
    mrg_mask = sel_r ? m1_r : m0_r;
    mrg_bits = sel_r ? g1_r : g0_r;
    mrg_byte = (old_byte & ~mrg_mask) | (mrg_bits & mrg_mask);
    mem_we   = (state_r == S_MERGE) && (act_r == ACT_BLIT);
    mem_ra   = addr_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mrg_byte;
    end
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      bg_r        <= 8'h00;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            act_r   <= in_ch.action;
            pend1_r <= blit_go1;
            addr1_r <= mk_addr(row_s[5:0], bidx1[4:0]);
            m0_r    <= full >> shift;
            g0_r    <= in_ch.glyph_bits >> shift;
            m1_r    <= full << (4'd8 - {1'b0, shift});
            g1_r    <= in_ch.glyph_bits << (4'd8 - {1'b0, shift});
            rdata_r <= 8'h00;
            wecho_r <= (in_ch.action == ACT_BLIT) ? width_sat : 4'd0;
            case (in_ch.action) inside
              ACT_CLEAR, ACT_FILL: begin
                valid_r <= '0;
                bg_r    <= (in_ch.action == ACT_FILL) ? 8'hFF : 8'h00;
                state_r <= S_DONE;
              end
              ACT_READ: begin
                addr_r  <= mk_addr(in_ch.read_row, in_ch.read_byte_index);
                state_r <= rd_ok ? S_ISSUE : S_DONE;
              end
              default: begin
                addr_r  <= blit_go0 ? mk_addr(row_s[5:0], bidx[4:0])
                                    : mk_addr(row_s[5:0], bidx1[4:0]);
                sel_r   <= !blit_go0;
                state_r <= (blit_go0 || blit_go1) ? S_ISSUE : S_DONE;
              end
            endcase
          end
        end
        S_ISSUE: begin
          state_r <= S_MERGE;
        end
        S_MERGE: begin
          if (act_r == ACT_READ) begin
            rdata_r <= old_byte;
            state_r <= S_DONE;
          end else begin
            valid_r[addr_r] <= 1'b1;
            if (!sel_r && pend1_r) begin
              addr_r  <= addr1_r;
              sel_r   <= 1'b1;
              state_r <= S_ISSUE;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_rdata_r <= rdata_r;
            out_wecho_r <= wecho_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = out_rdata_r;
  assign out_ch.width_echo = out_wecho_r;

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while another is in flight");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the completion step");

  a_second_byte: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MERGE && act_r == ACT_BLIT && sel_r |-> pend1_r)
    else $error("second byte merged without a pending second byte");

  a_blit_writes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MERGE && act_r == ACT_BLIT |=> valid_r[$past(addr_r)])
    else $error("merged byte not marked valid");
`endif

endmodule

// ===== verif/glyph_row_blit_framebuffer_top_tb.sv =====
module glyph_row_blit_framebuffer_top_tb;
  import gblit_pkg::*;

  localparam int RAND_ITEMS = 1525;
  localparam int HOLD_AT    = 1500;
  localparam int HOLD_LEN   = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE     = 12;

  typedef struct {
    action_t            action;
    logic [7:0]         glyph_bits;
    logic [3:0]         glyph_width;
    logic [5:0]         glyph_line;
    logic signed [7:0]  row_offset;
    logic signed [10:0] col_offset;
    logic [5:0]         read_row;
    logic [4:0]         read_byte_index;
  } fb_cmd_t;

  typedef struct {
    logic [7:0] read_data;
    logic [3:0] width_echo;
  } fb_reply_t;

  logic clk;
  logic rst_n;

  gblit_in_if  in_ch();
  gblit_out_if out_ch();

  glyph_row_blit_framebuffer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fb_cmd_t   cmd_q[$];
  fb_reply_t reply_q[$];
  logic [7:0] shadow_fb [ROWS][COL_BYTES];

  fb_cmd_t drv_cmd;
  int n_total;
  int n_accepted = 0;
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_cyc;
  int rx_pct;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic shadow_set_all(input logic [7:0] v);
    for (int r = 0; r < ROWS; r++)
      for (int b = 0; b < COL_BYTES; b++)
        shadow_fb[r][b] = v;
  endtask

  task automatic merge_shadow(input int row, input int idx, input logic [7:0] mask,
                              input logic [7:0] bits);
    if (idx >= 0 && idx < COL_BYTES)
      shadow_fb[row][idx] = (shadow_fb[row][idx] & ~mask) | (bits & mask);
  endtask

  // updates the shadow frame store and returns the reply the block owes for this command
  task automatic apply_cmd(input fb_cmd_t c, output fb_reply_t r);
    logic [3:0]  w;
    logic [7:0]  full;
    logic [15:0] spill_mask;
    logic [15:0] spill_bits;
    int row;
    int col;
    int sh;
    int idx;
    r.read_data  = 8'h00;
    r.width_echo = 4'd0;
    w = (c.glyph_width > 4'd8) ? 4'd8 : c.glyph_width;
    case (c.action)
      ACT_BLIT: begin
        r.width_echo = w;
        row = int'(c.glyph_line) + int'(c.row_offset);
        if (row >= 0 && row < ROWS) begin
          col  = int'(c.col_offset);
          sh   = col & 7;
          idx  = (col - sh) / 8;
          full = 8'(16'hFF00 >> w);
          merge_shadow(row, idx, full >> sh, c.glyph_bits >> sh);
          if (sh != 0) begin
            spill_mask = {8'h00, full} << (8 - sh);
            spill_bits = {8'h00, c.glyph_bits} << (8 - sh);
            merge_shadow(row, idx + 1, spill_mask[7:0], spill_bits[7:0]);
          end
        end
      end
      ACT_CLEAR: shadow_set_all(8'h00);
      ACT_FILL:  shadow_set_all(8'hFF);
      default: begin
        if (c.read_row < ROWS && c.read_byte_index < COL_BYTES)
          r.read_data = shadow_fb[c.read_row][c.read_byte_index];
      end
    endcase
  endtask

  function automatic fb_cmd_t mk_cmd(input action_t act, input logic [7:0] glyph,
                                     input logic [3:0] width, input logic [5:0] line,
                                     input int roff, input int coff,
                                     input logic [5:0] rrow, input logic [4:0] rbyte);
    fb_cmd_t c;
    c.action          = act;
    c.glyph_bits      = glyph;
    c.glyph_width     = width;
    c.glyph_line      = line;
    c.row_offset      = 8'(roff);
    c.col_offset      = 11'(coff);
    c.read_row        = rrow;
    c.read_byte_index = rbyte;
    return c;
  endfunction

  // mostly on-screen blits and in-range reads, with a share of raw field values
  function automatic fb_cmd_t random_cmd();
    fb_cmd_t c;
    int pick;
    int target_row;
    c = mk_cmd(ACT_READ, 8'($urandom), 4'($urandom), 6'($urandom), int'($urandom),
               int'($urandom), 6'($urandom), 5'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 57) begin
      c.action = ACT_BLIT;
      if ($urandom_range(0, 4) != 0)
        c.glyph_width = 4'($urandom_range(0, 8));
      if ($urandom_range(0, 3) != 0) begin
        target_row   = int'($urandom_range(0, ROWS + 1)) - 1;
        c.row_offset = 8'(target_row - int'(c.glyph_line));
      end
      if ($urandom_range(0, 9) < 7)
        c.col_offset = 11'(int'($urandom_range(0, COL_BYTES * 8 + 16)) - 8);
    end else if (pick < 60) begin
      c.action = ACT_CLEAR;
    end else if (pick < 63) begin
      c.action = ACT_FILL;
    end else begin
      c.action = ACT_READ;
      if ($urandom_range(0, 4) != 0) begin
        c.read_row        = 6'($urandom_range(0, ROWS - 1));
        c.read_byte_index = 5'($urandom_range(0, COL_BYTES - 1));
      end
    end
    return c;
  endfunction

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    fb_reply_t r;
    if (!rst_n) begin
      in_ch.valid           <= 1'b0;
      in_ch.action          <= ACT_BLIT;
      in_ch.glyph_bits      <= 8'h00;
      in_ch.glyph_width     <= 4'd0;
      in_ch.glyph_line      <= 6'd0;
      in_ch.row_offset      <= 8'sd0;
      in_ch.col_offset      <= 11'sd0;
      in_ch.read_row        <= 6'd0;
      in_ch.read_byte_index <= 5'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_cmd(drv_cmd, r);
        reply_q.push_back(r);
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || cmd_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          drv_cmd = cmd_q.pop_front();
          in_ch.action          <= drv_cmd.action;
          in_ch.glyph_bits      <= drv_cmd.glyph_bits;
          in_ch.glyph_width     <= drv_cmd.glyph_width;
          in_ch.glyph_line      <= drv_cmd.glyph_line;
          in_ch.row_offset      <= drv_cmd.row_offset;
          in_ch.col_offset      <= drv_cmd.col_offset;
          in_ch.read_row        <= drv_cmd.read_row;
          in_ch.read_byte_index <= drv_cmd.read_byte_index;
          in_ch.valid           <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver: random readiness at a periodically redrawn rate, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_cyc = 0;
      rx_pct = 100;
    end else begin
      rx_cyc++;
      if (rx_cyc % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: rx_pct = 100;
          1: rx_pct = 75;
          2: rx_pct = 40;
          default: rx_pct = 10;
        endcase
      end
      if (rx_cyc >= HOLD_AT && rx_cyc < HOLD_AT + HOLD_LEN)
        out_ch.ready <= 1'b0;
      else
        out_ch.ready <= ($urandom_range(1, 100) <= rx_pct);
    end
  end

  always @(posedge clk) begin
    fb_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result, read_data %02h width_echo %0d", $time,
                 out_ch.read_data, out_ch.width_echo);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (out_ch.read_data !== want.read_data) begin
          $display("%0t: read_data expected %02h got %02h", $time, want.read_data,
                   out_ch.read_data);
          errors++;
        end
        if (out_ch.width_echo !== want.width_echo) begin
          $display("%0t: width_echo expected %0d got %0d", $time, want.width_echo,
                   out_ch.width_echo);
          errors++;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL glyph_row_blit_framebuffer_top");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    shadow_set_all(8'h00);

    // reset contents, fill and its last byte, out-of-range read, clear
    cmd_q.push_back(mk_cmd(ACT_READ, 8'h00, 4'd0, 6'd0, 0, 0, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_FILL, 8'h00, 4'd0, 6'd0, 0, 0, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_READ, 8'h00, 4'd0, 6'd0, 0, 0, 6'(ROWS - 1),
                           5'(COL_BYTES - 1)));
    cmd_q.push_back(mk_cmd(ACT_READ, 8'hFF, 4'd15, 6'd63, -1, -1, 6'd63, 5'd31));
    cmd_q.push_back(mk_cmd(ACT_CLEAR, 8'hFF, 4'd15, 6'd63, -1, -1, 6'd0, 5'd0));
    // aligned full-width blit, then width saturation across two bytes
    cmd_q.push_back(mk_cmd(ACT_BLIT, 8'hA5, 4'd8, 6'd0, 0, 0, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_READ, 8'h00, 4'd0, 6'd0, 0, 0, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_BLIT, 8'hFF, 4'd15, 6'd1, 0, 3, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_READ, 8'h00, 4'd0, 6'd0, 0, 0, 6'd1, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_READ, 8'h00, 4'd0, 6'd0, 0, 0, 6'd1, 5'd1));
    // zero width, rows above and below the screen
    cmd_q.push_back(mk_cmd(ACT_BLIT, 8'hFF, 4'd0, 6'd2, 0, 0, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_BLIT, 8'hFF, 4'd8, 6'd0, -128, 0, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_BLIT, 8'hFF, 4'd8, 6'd63, 127, 0, 6'd0, 5'd0));
    // left edge off screen: first byte skipped, second written
    cmd_q.push_back(mk_cmd(ACT_BLIT, 8'h81, 4'd8, 6'd2, 0, -3, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_READ, 8'h00, 4'd0, 6'd0, 0, 0, 6'd2, 5'd0));
    // right edge: spill byte past the last column is dropped
    cmd_q.push_back(mk_cmd(ACT_BLIT, 8'hF0, 4'd4, 6'd0, 3, COL_BYTES * 8 - 5, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_READ, 8'h00, 4'd0, 6'd0, 0, 0, 6'd3, 5'(COL_BYTES - 1)));
    // column extremes
    cmd_q.push_back(mk_cmd(ACT_BLIT, 8'hFF, 4'd8, 6'd0, 4, -1024, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_BLIT, 8'h55, 4'd7, 6'd0, 4, 1023, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_READ, 8'h00, 4'd0, 6'd0, 0, 0, 6'd4, 5'd0));
    // glyph bits beyond the width must not land
    cmd_q.push_back(mk_cmd(ACT_BLIT, 8'hFF, 4'd3, 6'd5, 0, 2, 6'd0, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_READ, 8'h00, 4'd0, 6'd0, 0, 0, 6'd5, 5'd0));
    cmd_q.push_back(mk_cmd(ACT_READ, 8'h00, 4'd0, 6'd0, 0, 0, 6'(ROWS), 5'd0));
    cmd_q.push_back(mk_cmd(ACT_READ, 8'h00, 4'd0, 6'd0, 0, 0, 6'd0, 5'(COL_BYTES)));

    repeat (RAND_ITEMS) cmd_q.push_back(random_cmd());
    n_total = cmd_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (reply_q.size() != 0) errors++;

    if (errors == 0)
      $display("PASS glyph_row_blit_framebuffer_top");
    else
      $display("FAIL glyph_row_blit_framebuffer_top");
    $finish;
  end

endmodule

// ===== sim.f =====
src/gblit_pkg.sv
src/gblit_in_if.sv
src/gblit_out_if.sv
src/glyph_row_blit_framebuffer_top.sv
verif/glyph_row_blit_framebuffer_top_tb.sv
